// ----- design/mlfd_pkg.sv -----
package mlfd_pkg;

   localparam logic [31:0] START_WORD_RESET = 32'h9D74_C714;
   localparam logic [31:0] END_WORD_RESET   = 32'hD7A1_52C8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      REG_START_WORD = 1'b0,
      REG_END_WORD   = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_VALID    = 2'd0,
      ST_SHORT    = 2'd1,
      ST_BAD_HEAD = 2'd2,
      ST_BAD_TAIL = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      KIND_BODY   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // everything one request produces: an optional body byte and an optional status
   typedef struct packed {
      logic        has_body;
      logic [7:0]  body_byte;
      logic        has_status;
      status_type  status;
      logic [15:0] command_id;
   } entry_type;

endpackage

// ----- design/mlfd_front.sv -----
module mlfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_buffer,
   input  logic [31:0]         start_word,
   input  logic [31:0]         end_word,
   output logic                push,
   output mlfd_pkg::entry_type push_entry
);

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_SKIP   = 5'b00010,
      PH_BODY   = 5'b00100,
      PH_TAIL   = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   localparam logic [3:0] HC_HEAD_END = 4'd3;
   localparam logic [3:0] HC_CMD_END  = 4'd5;
   localparam logic [3:0] HC_SKIP_END = 4'd7;
   localparam logic [3:0] HC_BODY_END = 4'd11;
   localparam logic [1:0] TC_END      = 2'd3;

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [31:0] word_shift_ff, word_shift_in;
   logic [15:0] command_ff, command_in;
   logic [15:0] skip_ff, skip_in;
   logic [31:0] body_ff, body_in;
   logic [1:0]  tail_count_ff, tail_count_in;

   logic [31:0]         shifted;
   mlfd_pkg::entry_type entry;

   assign shifted = {word_shift_ff[23:0], data_byte};

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      word_shift_in   = word_shift_ff;
      command_in      = command_ff;
      skip_in         = skip_ff;
      body_in         = body_ff;
      tail_count_in   = tail_count_ff;
      entry.has_body   = 1'b0;
      entry.body_byte  = data_byte;
      entry.has_status = 1'b0;
      entry.status     = mlfd_pkg::ST_VALID;

      case (phase_ff)
         PH_HEADER: begin
            word_shift_in = shifted;
            if (header_count_ff == HC_HEAD_END) begin
               if (shifted != start_word) begin
                  entry.has_status = 1'b1;
                  entry.status     = mlfd_pkg::ST_BAD_HEAD;
                  phase_in         = PH_DONE;
               end
            end else if (header_count_ff == HC_CMD_END) begin
               command_in = shifted[15:0];
            end else if (header_count_ff == HC_SKIP_END) begin
               skip_in = shifted[15:0];
            end else if (header_count_ff == HC_BODY_END) begin
               body_in = shifted;
            end
            if (phase_in == PH_HEADER) begin
               if (header_count_ff >= HC_BODY_END) begin
                  header_count_in = 4'd0;
                  if (skip_in != 16'd0) begin
                     phase_in = PH_SKIP;
                  end else if (body_in != 32'd0) begin
                     phase_in = PH_BODY;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end else begin
                  header_count_in = header_count_ff + 4'd1;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 16'd1;
            if (skip_in == 16'd0) begin
               phase_in = (body_ff != 32'd0) ? PH_BODY : PH_TAIL;
            end
         end
         PH_BODY: begin
            entry.has_body = 1'b1;
            body_in        = body_ff - 32'd1;
            if (body_in == 32'd0) begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            word_shift_in = shifted;
            if (tail_count_ff == TC_END) begin
               entry.has_status = 1'b1;
               entry.status     = (shifted == end_word) ? mlfd_pkg::ST_VALID
                                                        : mlfd_pkg::ST_BAD_TAIL;
               tail_count_in    = 2'd0;
               phase_in         = PH_DONE;
            end else begin
               tail_count_in = tail_count_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase

      entry.command_id = command_in;

      // buffer ended: short status unless the frame was decided, then the parser restarts
      if (end_of_buffer) begin
         if (phase_in != PH_DONE) begin
            entry.has_status = 1'b1;
            entry.status     = mlfd_pkg::ST_SHORT;
         end
         phase_in        = PH_HEADER;
         header_count_in = 4'd0;
         word_shift_in   = 32'd0;
         command_in      = 16'd0;
         skip_in         = 16'd0;
         body_in         = 32'd0;
         tail_count_in   = 2'd0;
      end
   end

   assign push       = accept && (entry.has_body || entry.has_status);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 4'd0;
         word_shift_ff   <= 32'd0;
         command_ff      <= 16'd0;
         skip_ff         <= 16'd0;
         body_ff         <= 32'd0;
         tail_count_ff   <= 2'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         word_shift_ff   <= word_shift_in;
         command_ff      <= command_in;
         skip_ff         <= skip_in;
         body_ff         <= body_in;
         tail_count_ff   <= tail_count_in;
      end
   end

endmodule

// ----- design/mlfd_queue.sv -----
module mlfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mlfd_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output mlfd_pkg::entry_type head_entry
);

   mlfd_pkg::entry_type entries_ff [mlfd_pkg::QUEUE_DEPTH];

   logic [mlfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mlfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mlfd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [mlfd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      mlfd_pkg::QUEUE_CNT_W'(mlfd_pkg::QUEUE_DEPTH);
   localparam logic [mlfd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      mlfd_pkg::QUEUE_PTR_W'(mlfd_pkg::QUEUE_DEPTH - 1);

   assign full       = (count_ff == CNT_FULL);
   assign empty      = (count_ff == '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/mlfd_back.sv -----
module mlfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  mlfd_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [7:0]          rsp_body_byte,
   output logic [15:0]         rsp_command_id,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   // status still owed from an entry whose body byte went out first
   logic                 pend_ff, pend_in;
   mlfd_pkg::status_type pend_status_ff, pend_status_in;
   logic [15:0]          pend_command_ff, pend_command_in;

   logic                 valid_ff, valid_in;
   mlfd_pkg::kind_type   kind_ff, kind_in;
   logic [7:0]           body_ff, body_in;
   logic [15:0]          command_ff, command_in;
   mlfd_pkg::status_type status_ff, status_in;
   logic                 load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      pop             = 1'b0;
      pend_in         = pend_ff;
      pend_status_in  = pend_status_ff;
      pend_command_in = pend_command_ff;
      valid_in        = valid_ff;
      kind_in         = kind_ff;
      body_in         = body_ff;
      command_in      = command_ff;
      status_in       = status_ff;
      if (load) begin
         valid_in = 1'b0;
         if (pend_ff) begin
            pend_in    = 1'b0;
            valid_in   = 1'b1;
            kind_in    = mlfd_pkg::KIND_STATUS;
            body_in    = 8'd0;
            command_in = pend_command_ff;
            status_in  = pend_status_ff;
         end else if (!empty) begin
            pop        = 1'b1;
            valid_in   = 1'b1;
            command_in = head_entry.command_id;
            if (head_entry.has_body) begin
               kind_in         = mlfd_pkg::KIND_BODY;
               body_in         = head_entry.body_byte;
               status_in       = mlfd_pkg::ST_VALID;
               pend_in         = head_entry.has_status;
               pend_status_in  = head_entry.status;
               pend_command_in = head_entry.command_id;
            end else begin
               kind_in   = mlfd_pkg::KIND_STATUS;
               body_in   = 8'd0;
               status_in = head_entry.status;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff  <= pend_status_in;
      pend_command_ff <= pend_command_in;
      kind_ff         <= kind_in;
      body_ff         <= body_in;
      command_ff      <= command_in;
      status_ff       <= status_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_body_byte  = body_ff;
   assign rsp_command_id = command_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = (kind_ff == mlfd_pkg::KIND_STATUS);

endmodule

// ----- design/magic_length_frame_decoder_core.sv -----
// Byte-stream deframer. Each request carries one byte of a buffer and a flag marking the
// buffer's final byte. Frames are head magic, command id, extra-header size, body size,
// extra header (dropped), body (forwarded byte by byte), tail magic.
// Responses are either body bytes (kind 0) or one closing status (kind 1, last 1) carrying
// the command id and a code: valid, short buffer, bad head magic or bad tail magic.
// The head and tail magic words are set through the configuration write port (index 0
// and 1) and should only be changed while no request is in flight.
// Throughput: one request per cycle while req_ready is high. A request yields zero, one or
// two responses; the only two-response case is a body byte that also ends the buffer, which
// yields the body byte followed by a short-buffer status.
// Path: the parser pushes each entry into a four-entry queue at the accepting edge, and the
// output stage pops it from the queue into the response register once that register is
// free or being taken.
// When the receiver stalls, responses pile up in the queue and req_ready drops once it
// is full; the response register holds steady until taken.
// Reset (synchronous) clears the parser to expect a header, empties the queue and
// restores the default magic words; req_ready is low while reset is high.
module magic_length_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic [15:0] rsp_command_id,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic [31:0] start_word_ff;
   logic [31:0] end_word_ff;

   logic                accept;
   logic                push;
   logic                pop;
   logic                full;
   logic                empty;
   mlfd_pkg::entry_type push_entry;
   mlfd_pkg::entry_type head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= mlfd_pkg::START_WORD_RESET;
         end_word_ff   <= mlfd_pkg::END_WORD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mlfd_pkg::REG_START_WORD: start_word_ff <= csr_write_data;
            mlfd_pkg::REG_END_WORD:   end_word_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !full && !reset;
   assign accept    = req_valid && req_ready;

   mlfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .start_word    (start_word_ff),
      .end_word      (end_word_ff),
      .push          (push),
      .push_entry    (push_entry)
   );

   mlfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head_entry (head_entry)
   );

   mlfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (empty),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_body_byte  (rsp_body_byte),
      .rsp_command_id (rsp_command_id),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule
